/* hdl/ffpa_pkg.sv */
// Package for the first-fit partition allocator: transfer structs, table entry
// type, status codes and controller state encoding.
// Depends on nothing; imported by first_fit_partition_allocator.
package ffpa_pkg;

    localparam int unsigned FUNC_ALLOC = 0;
    localparam int unsigned FUNC_FREE  = 1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_NOJOB   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic       func;
        logic [7:0] req_size;
        logic [7:0] job_id;
    } cmd_t;

    typedef struct packed {
        status_t    status;
        logic [6:0] start_addr;
        logic [7:0] part_len;
        logic [4:0] part_total;
    } rsp_t;

    typedef struct packed {
        logic [7:0] start;
        logic [7:0] size;
        logic [7:0] owner;
    } entry_t;

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_SHUP  = 8'b0000_1000,
        S_WRNEW = 8'b0001_0000,
        S_WROWN = 8'b0010_0000,
        S_FNEXT = 8'b0100_0000,
        S_SHDN  = 8'b1000_0000
    } state_t;

endpackage

/* hdl/first_fit_partition_allocator.sv */
// First-fit partition allocator: a request scans the table for the first free fit or the
// owner's entry. A split moves entries above up (S_SHUP), writes the free rest (S_WRNEW), then
// the owned part (S_WROWN); a free writes the released entry, merged with free neighbours, then
// moves entries above down (S_SHDN) if it merged. A zero job id or a zero alloc size is answered
// from idle with no scan; the next request may be accepted at the edge that takes the result. Reset
// holds busy while the whole-memory entry is written; the receiver cannot stall. Depends on ffpa_pkg.
module first_fit_partition_allocator
    import ffpa_pkg::*;
#(
    parameter int unsigned MEM_UNITS = 128,
    parameter int unsigned MAX_PARTS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output rsp_t result
);

    localparam int unsigned AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int unsigned CW = $clog2(MAX_PARTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PARTS);

    // The partition table lives in one synchronous memory with one write and
    // one registered read port. Entries at or above the count are never used.
    entry_t mem [MAX_PARTS];
    entry_t rd_data;
    logic [AW-1:0] rd_addr;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    entry_t wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;      // entry whose data is on rd_data while scanning
    logic [CW-1:0] rptr_reg, rptr_next;    // next address to read while shifting
    logic [AW-1:0] raddr_reg, raddr_next;  // address of the read in flight
    logic rv_reg, rv_next;                 // a shift read is in flight
    logic [1:0] dist_reg, dist_next;       // shift-down distance after a merge
    cmd_t cmd_reg, cmd_next;
    entry_t cur_reg, cur_next;
    entry_t prev_reg, prev_next;
    logic done_reg, done_next;
    rsp_t result_reg, result_next;

    logic finish;
    status_t fin_status;
    logic [7:0] fin_start;
    logic [7:0] fin_len;
    logic hit;
    logic last;
    logic nf;
    logic pf;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        rptr_next   = rptr_reg;
        raddr_next  = raddr_reg;
        rv_next     = 1'b0;
        dist_next   = dist_reg;
        cmd_next    = cmd_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        finish      = 1'b0;
        fin_status  = ST_OK;
        fin_start   = '0;
        fin_len     = '0;
        hit         = 1'b0;
        last        = 1'b0;
        nf          = 1'b0;
        pf          = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                // The whole memory starts out as one free partition.
                wr_en       = 1'b1;
                wr_addr     = '0;
                wr_data     = '{start: 8'd0, size: 8'(MEM_UNITS), owner: 8'd0};
                state_next  = S_IDLE;
            end

            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    idx_next = '0;
                    rd_addr  = '0;
                    if (cmd.job_id == 8'd0)
                    begin
                        finish     = 1'b1;
                        fin_status = ST_NOJOB;
                    end
                    else if (cmd.func == 1'(FUNC_ALLOC) && cmd.req_size == 8'd0)
                    begin
                        finish     = 1'b1;
                        fin_status = ST_NOSPACE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                rd_addr = idx_reg + AW'(1);
                last    = (CW'(idx_reg) + CW'(1)) == count_reg;
                if (cmd_reg.func == 1'(FUNC_ALLOC))
                begin
                    hit = (rd_data.owner == 8'd0) && (rd_data.size >= cmd_reg.req_size);
                end
                else
                begin
                    hit = rd_data.owner == cmd_reg.job_id;
                end
                cur_next = rd_data;
                if (hit && cmd_reg.func == 1'(FUNC_ALLOC))
                begin
                    if (rd_data.size == cmd_reg.req_size)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = idx_reg;
                        wr_data    = '{start: rd_data.start, size: rd_data.size,
                                       owner: cmd_reg.job_id};
                        finish     = 1'b1;
                        fin_start  = rd_data.start;
                        fin_len    = rd_data.size;
                        state_next = S_IDLE;
                    end
                    else if (count_reg == MAX_CNT)
                    begin
                        finish     = 1'b1;
                        fin_status = ST_FULL;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rptr_next  = count_reg - CW'(1);
                        state_next = S_SHUP;
                    end
                end
                else if (hit)
                begin
                    // The read of the entry above is already under way.
                    state_next = S_FNEXT;
                end
                else if (last)
                begin
                    finish     = 1'b1;
                    fin_status = (cmd_reg.func == 1'(FUNC_ALLOC)) ? ST_NOSPACE : ST_NOJOB;
                    state_next = S_IDLE;
                end
                else
                begin
                    prev_next = rd_data;
                    idx_next  = idx_reg + AW'(1);
                end
            end

            S_SHUP:
            begin
                // Move entries above the split point up by one, top first.
                if (rv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = raddr_reg + AW'(1);
                    wr_data = rd_data;
                end
                if (rptr_reg > CW'(idx_reg))
                begin
                    rd_addr    = rptr_reg[AW-1:0];
                    raddr_next = rptr_reg[AW-1:0];
                    rv_next    = 1'b1;
                    rptr_next  = rptr_reg - CW'(1);
                end
                else if (!rv_reg)
                begin
                    state_next = S_WRNEW;
                end
            end

            S_WRNEW:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg + AW'(1);
                wr_data    = '{start: cur_reg.start + cmd_reg.req_size,
                               size: cur_reg.size - cmd_reg.req_size, owner: 8'd0};
                state_next = S_WROWN;
            end

            S_WROWN:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = '{start: cur_reg.start, size: cmd_reg.req_size,
                               owner: cmd_reg.job_id};
                count_next = count_reg + CW'(1);
                finish     = 1'b1;
                fin_start  = cur_reg.start;
                fin_len    = cmd_reg.req_size;
                state_next = S_IDLE;
            end

            S_FNEXT:
            begin
                // rd_data holds the entry above the released one.
                nf = ((CW'(idx_reg) + CW'(1)) < count_reg) && (rd_data.owner == 8'd0);
                pf = (idx_reg != '0) && (prev_reg.owner == 8'd0);
                wr_en = 1'b1;
                state_next = S_SHDN;
                if (nf && pf)
                begin
                    wr_addr   = idx_reg - AW'(1);
                    wr_data   = '{start: prev_reg.start,
                                  size: prev_reg.size + cur_reg.size + rd_data.size,
                                  owner: 8'd0};
                    dist_next = 2'd2;
                    rptr_next = CW'(idx_reg) + CW'(2);
                end
                else if (nf)
                begin
                    wr_addr   = idx_reg;
                    wr_data   = '{start: cur_reg.start, size: cur_reg.size + rd_data.size,
                                  owner: 8'd0};
                    dist_next = 2'd1;
                    rptr_next = CW'(idx_reg) + CW'(2);
                end
                else if (pf)
                begin
                    wr_addr   = idx_reg - AW'(1);
                    wr_data   = '{start: prev_reg.start, size: prev_reg.size + cur_reg.size,
                                  owner: 8'd0};
                    dist_next = 2'd1;
                    rptr_next = CW'(idx_reg) + CW'(1);
                end
                else
                begin
                    wr_addr    = idx_reg;
                    wr_data    = '{start: cur_reg.start, size: cur_reg.size, owner: 8'd0};
                    finish     = 1'b1;
                    fin_start  = cur_reg.start;
                    fin_len    = cur_reg.size;
                    state_next = S_IDLE;
                end
            end

            S_SHDN:
            begin
                // Close the gap left by merged entries, bottom first.
                if (rv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = raddr_reg - AW'(dist_reg);
                    wr_data = rd_data;
                end
                if (rptr_reg < count_reg)
                begin
                    rd_addr    = rptr_reg[AW-1:0];
                    raddr_next = rptr_reg[AW-1:0];
                    rv_next    = 1'b1;
                    rptr_next  = rptr_reg + CW'(1);
                end
                else if (!rv_reg)
                begin
                    count_next = count_reg - CW'(dist_reg);
                    finish     = 1'b1;
                    fin_start  = cur_reg.start;
                    fin_len    = cur_reg.size;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        done_next   = finish;
        result_next = result_reg;
        if (finish)
        begin
            result_next.status     = fin_status;
            result_next.start_addr = (fin_status == ST_OK) ? fin_start[6:0] : 7'd0;
            result_next.part_len   = (fin_status == ST_OK) ? fin_len : 8'd0;
            result_next.part_total = 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            count_reg <= CW'(1);
            rv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        rptr_reg   <= rptr_next;
        raddr_reg  <= raddr_next;
        dist_reg   <= dist_next;
        cmd_reg    <= cmd_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // The table never empties and never outgrows its memory.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= MAX_CNT))
        else $error("partition count out of range");

    // The table is only written while a request or the initial fill is in hand.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> busy)
        else $error("table written while idle");

    // A scan never looks past the last table entry.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CW'(idx_reg) < count_reg))
        else $error("scan beyond table");

    // No shift read is left in flight once the block goes idle.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !rv_reg)
        else $error("shift read pending while idle");

endmodule
